@@ hw/rtl/csvp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types and constants for the RFC4180 CSV byte parser: result kinds,
// error codes, special characters and the result record.
// ----------------------------------------------------------------------------
package csvp_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_FEND  = 3'd1,
        KIND_REND  = 3'd2,
        KIND_OK    = 3'd3,
        KIND_ERR   = 3'd4
    } kind_t;

    // Error codes carried with KIND_ERR
    typedef enum logic [2:0] {
        ERR_UNTERM_QUOTE = 3'd0,
        ERR_JUNK_AFTER_Q = 3'd1,
        ERR_STRAY_QUOTE  = 3'd2,
        ERR_COUNT        = 3'd3,
        ERR_TOO_MANY     = 3'd4,
        ERR_NO_HEADER    = 3'd5
    } err_code_t;

    // Special characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // One result record
    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_char;
        err_code_t  error_code;
        logic [7:0] row_fields;
        logic       is_last;
    } result_t;

endpackage

@@ hw/rtl/csvp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvp_if
// Valid/ready channels of the CSV parser: the byte channel and the result
// channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface csvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_input;

    modport source (output valid, output in_char, output end_of_input, input ready);
    modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

interface csvp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_char;
    logic [2:0] error_code;
    logic [7:0] row_fields;
    logic       is_last;

    modport source (output valid, output kind, output out_char, output error_code,
                    output row_fields, output is_last, input ready);
    modport sink   (input valid, input kind, input out_char, input error_code,
                    input row_fields, input is_last, output ready);
endinterface

@@ hw/rtl/csv_rfc4180_byte_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_rfc4180_byte_parser
// Strict RFC4180 CSV parser, one byte per transaction. The header row fixes
// the field count; later rows stream content bytes, field-end and row-end
// markers. Errors are sticky until the end-of-input transaction.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                        results
//  byte_ch    in   in_char[7:0], end_of_input                     -
//  result_ch  out  kind[2:0], out_char[7:0], error_code[2:0],     0..2 per
//                  row_fields[7:0], is_last                       byte
//
//  One byte is accepted per cycle into the input stage; its results are
//  decoded from there into the result queue. An end-of-input transaction
//  that closes a data row gives two results; any other gives at most one.
//  The rate is set by the two-entry result queue: a byte is decoded only when
//  the queue has room for all of its results.
//  rst_n clears parse state, the input stage and the queue asynchronously.
//  A stalled result channel backs up into byte_ch.ready after two entries.
// ----------------------------------------------------------------------------
module csv_rfc4180_byte_parser
    import csvp_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = 255
)(
    input  logic            clk,
    input  logic            rst_n,
    csvp_in_if.sink         byte_ch,
    csvp_out_if.source      result_ch
);

    localparam logic [8:0] FIELD_LIMIT = (MAX_FIELDS > 255) ? 9'd255 : 9'(MAX_FIELDS);

    typedef enum logic [1:0] {
        PS_START  = 2'd0,
        PS_UNQ    = 2'd1,
        PS_QUOTED = 2'd2,
        PS_QSEEN  = 2'd3
    } pstate_t;

    // Input stage
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_char_reg;
    logic       stage_eof_reg;

    // Parse state
    pstate_t    ps_reg, ps_next;
    logic       rhc_reg, rhc_next;
    logic       hdr_reg, hdr_next;
    logic [7:0] exp_reg, exp_next;
    logic [7:0] fields_reg, fields_next;
    logic       err_reg, err_next;
    err_code_t  code_reg, code_next;

    // Result queue
    result_t    q_reg [2];
    result_t    q_next [2];
    logic [1:0] cnt_reg, cnt_next;

    // Decode outputs
    result_t    r0, r1;
    logic [1:0] n_res;
    logic       proc;
    logic       pop;
    logic       accept;
    logic       nl;
    logic       row_empty;
    logic       do_comma, do_close;
    logic       emit, raise;
    result_t    emit_res;
    err_code_t  raise_code;
    logic [7:0] total;
    logic [1:0] cnt_pop;

    // Handshakes
    assign pop    = result_ch.valid && result_ch.ready;
    assign proc   = stage_valid_reg && ({1'b0, cnt_reg} + {1'b0, n_res} <= 3'd2);
    assign byte_ch.ready = !stage_valid_reg || proc;
    assign accept = byte_ch.valid && byte_ch.ready;

    assign nl        = (stage_char_reg == CH_CR) || (stage_char_reg == CH_LF);
    assign row_empty = (ps_reg == PS_START) && !rhc_reg && (fields_reg == 8'd0);
    assign total     = fields_reg + 8'd1;

    // Byte decode and next parse state
    always_comb
    begin
        ps_next     = ps_reg;
        rhc_next    = rhc_reg;
        hdr_next    = hdr_reg;
        exp_next    = exp_reg;
        fields_next = fields_reg;
        err_next    = err_reg;
        code_next   = code_reg;
        do_comma    = 1'b0;
        do_close    = 1'b0;
        emit        = 1'b0;
        raise       = 1'b0;
        raise_code  = ERR_UNTERM_QUOTE;
        emit_res    = '{kind: KIND_BYTE, out_char: 8'd0, error_code: ERR_UNTERM_QUOTE,
                        row_fields: 8'd0, is_last: 1'b1};
        r0          = emit_res;
        r1          = emit_res;
        n_res       = 2'd0;

        if (stage_eof_reg)
        begin
            // End of input: report and return to reset state
            r0.kind = KIND_ERR;
            n_res   = 2'd1;
            if (err_reg)
                r0.error_code = code_reg;
            else if (ps_reg == PS_QUOTED)
                r0.error_code = ERR_UNTERM_QUOTE;
            else if (!row_empty)
            begin
                if (!hdr_reg)
                    r0.kind = KIND_OK;
                else if (total != exp_reg)
                    r0.error_code = ERR_COUNT;
                else
                begin
                    r0.kind       = KIND_REND;
                    r0.row_fields = total;
                    r0.is_last    = 1'b0;
                    r1.kind       = KIND_OK;
                    n_res         = 2'd2;
                end
            end
            else if (hdr_reg)
                r0.kind = KIND_OK;
            else
                r0.error_code = ERR_NO_HEADER;
            ps_next     = PS_START;
            rhc_next    = 1'b0;
            hdr_next    = 1'b0;
            exp_next    = 8'd0;
            fields_next = 8'd0;
            err_next    = 1'b0;
            code_next   = ERR_UNTERM_QUOTE;
        end
        else if (!err_reg)
        begin
            unique case (ps_reg)
                PS_QUOTED:
                begin
                    if (stage_char_reg == CH_QUOTE)
                        ps_next = PS_QSEEN;
                    else
                    begin
                        emit              = hdr_reg;
                        emit_res.out_char = stage_char_reg;
                        rhc_next          = 1'b1;
                    end
                end
                PS_QSEEN:
                begin
                    if (stage_char_reg == CH_QUOTE)
                    begin
                        emit              = hdr_reg;
                        emit_res.out_char = CH_QUOTE;
                        ps_next           = PS_QUOTED;
                    end
                    else if (stage_char_reg == CH_COMMA)
                        do_comma = 1'b1;
                    else if (nl)
                        do_close = 1'b1;
                    else
                    begin
                        raise      = 1'b1;
                        raise_code = ERR_JUNK_AFTER_Q;
                    end
                end
                PS_START, PS_UNQ:
                begin
                    if (stage_char_reg == CH_QUOTE)
                    begin
                        if (ps_reg == PS_START)
                        begin
                            ps_next  = PS_QUOTED;
                            rhc_next = 1'b1;
                        end
                        else
                        begin
                            raise      = 1'b1;
                            raise_code = ERR_STRAY_QUOTE;
                        end
                    end
                    else if (stage_char_reg == CH_COMMA)
                    begin
                        rhc_next = 1'b1;
                        do_comma = 1'b1;
                    end
                    else if (nl)
                        do_close = !row_empty;
                    else
                    begin
                        emit              = hdr_reg;
                        emit_res.out_char = stage_char_reg;
                        rhc_next          = 1'b1;
                        ps_next           = PS_UNQ;
                    end
                end
            endcase

            // Field end on a comma, with the field limit check
            if (do_comma)
            begin
                if ({1'b0, fields_reg} + 9'd1 >= FIELD_LIMIT)
                begin
                    raise      = 1'b1;
                    raise_code = ERR_TOO_MANY;
                end
                else
                begin
                    fields_next   = total;
                    emit          = hdr_reg;
                    emit_res.kind = KIND_FEND;
                    ps_next       = PS_START;
                end
            end

            // Row end: header sets the count, data rows must match it
            if (do_close)
            begin
                if (!hdr_reg)
                begin
                    exp_next = total;
                    hdr_next = 1'b1;
                end
                else if (total != exp_reg)
                begin
                    raise      = 1'b1;
                    raise_code = ERR_COUNT;
                end
                else
                begin
                    emit                = 1'b1;
                    emit_res.kind       = KIND_REND;
                    emit_res.row_fields = total;
                end
                fields_next = 8'd0;
                rhc_next    = 1'b0;
                ps_next     = PS_START;
            end

            if (raise)
            begin
                err_next  = 1'b1;
                code_next = raise_code;
                r0        = '{kind: KIND_ERR, out_char: 8'd0, error_code: raise_code,
                              row_fields: 8'd0, is_last: 1'b1};
                n_res     = 2'd1;
            end
            else if (emit)
            begin
                r0    = emit_res;
                n_res = 2'd1;
            end
        end
    end

    // Result queue: pop from the head, append behind what remains
    always_comb
    begin
        q_next  = q_reg;
        cnt_pop = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            cnt_pop   = cnt_reg - 2'd1;
        end
        cnt_next = cnt_pop;
        if (proc)
        begin
            if (n_res == 2'd2)
            begin
                q_next[0] = r0;
                q_next[1] = r1;
            end
            else if (n_res == 2'd1)
                q_next[cnt_pop[0]] = r0;
            cnt_next = cnt_pop + n_res;
        end
    end

    assign stage_valid_next = accept ? 1'b1 : (proc ? 1'b0 : stage_valid_reg);

    // State, stage and queue registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            ps_reg          <= PS_START;
            rhc_reg         <= 1'b0;
            hdr_reg         <= 1'b0;
            exp_reg         <= 8'd0;
            fields_reg      <= 8'd0;
            err_reg         <= 1'b0;
            code_reg        <= ERR_UNTERM_QUOTE;
            cnt_reg         <= 2'd0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            cnt_reg         <= cnt_next;
            if (proc)
            begin
                ps_reg     <= ps_next;
                rhc_reg    <= rhc_next;
                hdr_reg    <= hdr_next;
                exp_reg    <= exp_next;
                fields_reg <= fields_next;
                err_reg    <= err_next;
                code_reg   <= code_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_char_reg <= byte_ch.in_char;
            stage_eof_reg  <= byte_ch.end_of_input;
        end
        q_reg <= q_next;
    end

    // Result channel
    assign result_ch.valid      = (cnt_reg != 2'd0);
    assign result_ch.kind       = q_reg[0].kind;
    assign result_ch.out_char   = q_reg[0].out_char;
    assign result_ch.error_code = q_reg[0].error_code;
    assign result_ch.row_fields = q_reg[0].row_fields;
    assign result_ch.is_last    = q_reg[0].is_last;

endmodule

@@ hw/rtl/csvp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvp_checker
// Port-level checks on the CSV parser result channel, bound to the parser module.
// ----------------------------------------------------------------------------
module csvp_checker
    import csvp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] kind,
    input logic [7:0] out_char,
    input logic [2:0] error_code,
    input logic [7:0] row_fields,
    input logic       is_last
);

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_char)
            && $stable(error_code) && $stable(row_fields) && $stable(is_last))
        else $error("result changed while stalled");

    // Only error results carry an error code
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERR |-> error_code == 3'd0)
        else $error("error code on a non-error result");

    // Final status always closes a transaction's results
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_OK || kind == KIND_ERR) |-> is_last)
        else $error("status result not marked last");

    // A row end that is not last is followed at once by the ok status
    a_rend_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && kind == KIND_REND && !is_last
            |=> out_valid && kind == KIND_OK)
        else $error("row end at end of input not followed by ok");

endmodule

bind csv_rfc4180_byte_parser csvp_checker u_csvp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .kind       (result_ch.kind),
    .out_char   (result_ch.out_char),
    .error_code (result_ch.error_code),
    .row_fields (result_ch.row_fields),
    .is_last    (result_ch.is_last)
);

@@ sim/tb_csv_rfc4180_byte_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csv_rfc4180_byte_parser
// Self-checking bench for the CSV byte parser. A short directed table covers
// every result kind, four error codes and the byte extremes. Random CSV files
// follow: headers, quoted and plain fields, CR/LF/CRLF endings, blank lines,
// wrong field counts, injected junk and truncated files. One file drives a row
// past the field limit. Every accepted byte transaction is run through a
// behavioural parser in the bench, and every result transaction is compared
// with the oldest prediction. Both channels idle at random, and the result
// side holds off for a long stretch once so that the parser stalls its input.
// ----------------------------------------------------------------------------
module tb_csv_rfc4180_byte_parser;
    import csvp_pkg::*;

    localparam int MAX_FIELDS  = 255;
    localparam int FIELD_CAP   = (MAX_FIELDS > 255) ? 255 : MAX_FIELDS;
    localparam int DIR_ROWS    = 27;
    localparam int RAND_ITEMS  = 550;
    localparam int IDLE_PCT    = 34;
    localparam int STALL_AT    = DIR_ROWS + 60;
    localparam int HOLD_CYCLES = 60;
    localparam int CALM_FROM   = DIR_ROWS + 300;
    localparam int CALM_TO     = DIR_ROWS + 450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;

    // Zero code carried on results that are not errors
    localparam err_code_t NO_ERR = ERR_UNTERM_QUOTE;

    typedef enum logic [1:0] {
        AT_FIELD_START,
        IN_UNQUOTED,
        IN_QUOTED,
        QUOTE_SEEN
    } parse_st_t;

    // One byte transaction; fixed rows carry their single result typed in
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       fixed;
        kind_t      kind;
        logic [7:0] out_char;
        err_code_t  code;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n;

    csvp_in_if  byte_if ();
    csvp_out_if res_if ();

    csv_rfc4180_byte_parser #(
        .MAX_FIELDS (MAX_FIELDS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_if),
        .result_ch (res_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Directed table: reset case, byte extremes, every kind and four error codes
    stim_t directed_tbl [DIR_ROWS] = '{
        '{8'h00,    1'b1, 1'b1, KIND_ERR,  8'h00, ERR_NO_HEADER},
        '{8'h61,    1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_COMMA, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{8'h62,    1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_CR,    1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_LF,    1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{8'h00,    1'b0, 1'b1, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_COMMA, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{8'hFF,    1'b0, 1'b1, KIND_BYTE, 8'hFF, NO_ERR},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_LF,    1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{8'h00,    1'b1, 1'b1, KIND_OK,   8'h00, NO_ERR},
        '{8'h78,    1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_QUOTE, 1'b0, 1'b1, KIND_ERR,  8'h00, ERR_STRAY_QUOTE},
        '{8'h79,    1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{8'hFF,    1'b1, 1'b1, KIND_ERR,  8'h00, ERR_STRAY_QUOTE},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{8'h00,    1'b1, 1'b1, KIND_ERR,  8'h00, ERR_UNTERM_QUOTE},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 8'h00, NO_ERR},
        '{8'h7A,    1'b0, 1'b1, KIND_ERR,  8'h00, ERR_JUNK_AFTER_Q},
        '{8'h00,    1'b1, 1'b1, KIND_ERR,  8'h00, ERR_JUNK_AFTER_Q}
    };

    stim_t       stim_q [$];
    result_t     pending_results [$];
    int          rand_cnt = 0;
    int          accept_idx = 0;
    int          mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    // Parser state mirrored by the bench
    parse_st_t  ps;
    bit         in_content;
    bit         hdr_done;
    logic [7:0] hdr_fields;
    logic [7:0] row_fields_cnt;
    bit         err_sticky;
    err_code_t  sticky_code;

    // ------------------------------------------------------------------------
    // Behavioural parser
    // ------------------------------------------------------------------------
    function automatic void reset_parser();
        ps             = AT_FIELD_START;
        in_content     = 1'b0;
        hdr_done       = 1'b0;
        hdr_fields     = 8'd0;
        row_fields_cnt = 8'd0;
        err_sticky     = 1'b0;
        sticky_code    = NO_ERR;
    endfunction

    function automatic void put_result(input kind_t k, input logic [7:0] c,
                                       input err_code_t e, input logic [7:0] nf);
        result_t r;
        r.kind       = k;
        r.out_char   = c;
        r.error_code = e;
        r.row_fields = nf;
        r.is_last    = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void latch_error(input err_code_t e);
        err_sticky  = 1'b1;
        sticky_code = e;
        put_result(KIND_ERR, 8'h00, e, 8'd0);
    endfunction

    // Header bytes are consumed silently
    function automatic void data_byte(input logic [7:0] c);
        if (hdr_done)
            put_result(KIND_BYTE, c, NO_ERR, 8'd0);
    endfunction

    function automatic void finish_field();
        if (int'(row_fields_cnt) + 1 >= FIELD_CAP)
            latch_error(ERR_TOO_MANY);
        else
        begin
            row_fields_cnt = row_fields_cnt + 8'd1;
            if (hdr_done)
                put_result(KIND_FEND, 8'h00, NO_ERR, 8'd0);
            ps = AT_FIELD_START;
        end
    endfunction

    // Returns 0 when a data row has the wrong field count
    function automatic bit close_row();
        logic [7:0] total;
        bit         ok;
        total = row_fields_cnt + 8'd1;
        ok    = 1'b1;
        if (!hdr_done)
        begin
            hdr_fields = total;
            hdr_done   = 1'b1;
        end
        else if (total != hdr_fields)
            ok = 1'b0;
        else
            put_result(KIND_REND, 8'h00, NO_ERR, total);
        row_fields_cnt = 8'd0;
        in_content     = 1'b0;
        ps             = AT_FIELD_START;
        return ok;
    endfunction

    function automatic void predict_results(input logic [7:0] c, input logic eoi);
        int        first;
        bit        row_empty;
        bit        nl;
        bit        failed;
        err_code_t code;
        result_t   r;
        first     = pending_results.size();
        nl        = (c == CH_CR) || (c == CH_LF);
        row_empty = (ps == AT_FIELD_START) && !in_content && (row_fields_cnt == 8'd0);
        failed    = 1'b0;
        code      = NO_ERR;
        if (eoi)
        begin
            // End of file: report sticky error or finish the pending row
            if (err_sticky)
            begin
                failed = 1'b1;
                code   = sticky_code;
            end
            else if (ps == IN_QUOTED)
            begin
                failed = 1'b1;
                code   = ERR_UNTERM_QUOTE;
            end
            else if (!row_empty)
            begin
                if (!close_row())
                begin
                    failed = 1'b1;
                    code   = ERR_COUNT;
                end
            end
            if (!failed && !hdr_done)
            begin
                failed = 1'b1;
                code   = ERR_NO_HEADER;
            end
            if (failed)
                put_result(KIND_ERR, 8'h00, code, 8'd0);
            else
                put_result(KIND_OK, 8'h00, NO_ERR, 8'd0);
            reset_parser();
        end
        else if (!err_sticky)
        begin
            case (ps)
                IN_QUOTED:
                begin
                    if (c == CH_QUOTE)
                        ps = QUOTE_SEEN;
                    else
                    begin
                        data_byte(c);
                        in_content = 1'b1;
                    end
                end
                QUOTE_SEEN:
                begin
                    if (c == CH_QUOTE)
                    begin
                        // doubled quote is one literal quote
                        data_byte(CH_QUOTE);
                        ps = IN_QUOTED;
                    end
                    else if (c == CH_COMMA)
                        finish_field();
                    else if (nl)
                    begin
                        if (!close_row())
                            latch_error(ERR_COUNT);
                    end
                    else
                        latch_error(ERR_JUNK_AFTER_Q);
                end
                default:
                begin
                    if (c == CH_QUOTE)
                    begin
                        if (ps == AT_FIELD_START)
                        begin
                            ps         = IN_QUOTED;
                            in_content = 1'b1;
                        end
                        else
                            latch_error(ERR_STRAY_QUOTE);
                    end
                    else if (c == CH_COMMA)
                    begin
                        in_content = 1'b1;
                        finish_field();
                    end
                    else if (nl)
                    begin
                        // blank lines are skipped
                        if (!row_empty)
                        begin
                            if (!close_row())
                                latch_error(ERR_COUNT);
                        end
                    end
                    else
                    begin
                        data_byte(c);
                        in_content = 1'b1;
                        ps         = IN_UNQUOTED;
                    end
                end
            endcase
        end
        if (pending_results.size() > first)
        begin
            r = pending_results.pop_back();
            r.is_last = 1'b1;
            pending_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random CSV generation
    // ------------------------------------------------------------------------
    function automatic void add(input logic [7:0] c, input logic eoi);
        stim_t s;
        s.ch       = c;
        s.eoi      = eoi;
        s.fixed    = 1'b0;
        s.kind     = KIND_BYTE;
        s.out_char = 8'h00;
        s.code     = NO_ERR;
        stim_q.push_back(s);
        rand_cnt++;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    // Quoted content leans towards separators and line breaks
    function automatic logic [7:0] quoted_byte();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 5)
            c = CH_CR;
        else if (pick < 10)
            c = CH_LF;
        else if (pick < 15)
            c = CH_COMMA;
        else
        begin
            do
                c = 8'($urandom_range(255));
            while (c == CH_QUOTE);
        end
        return c;
    endfunction

    function automatic void gen_field();
        int len;
        int k;
        len = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 4);
        if ($urandom_range(99) < 40)
        begin
            add(CH_QUOTE, 1'b0);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    add(CH_QUOTE, 1'b0);
                    add(CH_QUOTE, 1'b0);
                end
                else
                    add(quoted_byte(), 1'b0);
            end
            add(CH_QUOTE, 1'b0);
        end
        else
        begin
            for (k = 0; k < len; k++)
                add(plain_byte(), 1'b0);
        end
        // occasional junk: stray quotes, bytes after a closing quote
        if ($urandom_range(99) < 3)
            add($urandom_range(1) ? CH_QUOTE : 8'($urandom_range(255)), 1'b0);
    endfunction

    function automatic void gen_row(input int n, input bit term);
        int f;
        for (f = 0; f < n; f++)
        begin
            gen_field();
            if (f < n - 1)
                add(CH_COMMA, 1'b0);
        end
        if (term)
        begin
            case ($urandom_range(2))
                0: add(CH_CR, 1'b0);
                1: add(CH_LF, 1'b0);
                default:
                begin
                    add(CH_CR, 1'b0);
                    add(CH_LF, 1'b0);
                end
            endcase
            if ($urandom_range(99) < 10)
                add($urandom_range(1) ? CH_CR : CH_LF, 1'b0);
        end
    endfunction

    function automatic void gen_file();
        int cols;
        int rows;
        int r;
        int n;
        if ($urandom_range(99) < 4)
        begin
            // empty file
            add(8'($urandom_range(255)), 1'b1);
            return;
        end
        cols = ($urandom_range(99) < 15) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        rows = $urandom_range(1, 6);
        gen_row(cols, 1'b1);
        for (r = 0; r < rows; r++)
        begin
            n = cols;
            if ($urandom_range(99) < 8)
                n = (cols > 1 && $urandom_range(1) == 1) ? cols - 1 : cols + 1;
            gen_row(n, (r < rows - 1) || ($urandom_range(99) < 70));
        end
        // truncated file inside a quoted field
        if ($urandom_range(99) < 5)
        begin
            add(CH_QUOTE, 1'b0);
            add(plain_byte(), 1'b0);
        end
        add(8'($urandom_range(255)), 1'b1);
    endfunction

    // Header row up to the widest legal count, then one comma over the limit
    function automatic void gen_wide_file();
        repeat (FIELD_CAP) add(CH_COMMA, 1'b0);
        add(8'hA5, 1'b1);
    endfunction

    function automatic void build_stimulus();
        int i;
        bit wide_done;
        wide_done = 1'b0;
        for (i = 0; i < DIR_ROWS; i++)
            stim_q.push_back(directed_tbl[i]);
        while (rand_cnt < RAND_ITEMS)
        begin
            if (!wide_done && rand_cnt >= 250)
            begin
                gen_wide_file();
                wide_done = 1'b1;
            end
            gen_file();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Byte channel driver
    // ------------------------------------------------------------------------
    task automatic send_item(input stim_t s, input int idx);
        bit ready_seen;
        calm = (idx >= CALM_FROM) && (idx < CALM_TO);
        if (idx == STALL_AT)
            hold_req = 1'b1;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid        <= 1'b1;
        byte_if.in_char      <= s.ch;
        byte_if.end_of_input <= s.eoi;
        // ready is stable by the falling edge
        do
        begin
            @(negedge clk);
            ready_seen = byte_if.ready;
            @(posedge clk);
        end
        while (!ready_seen);
    endtask

    // Result channel: random back-pressure plus one long hold-off
    initial
    begin : result_sink
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: predict on byte transactions, compare result transactions
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input result_t want);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            $display("mismatch at %0t (%s): expected kind=%0d char=%02h code=%0d fields=%0d last=%0b",
                     $realtime, what, want.kind, want.out_char, want.error_code,
                     want.row_fields, want.is_last);
            $display("    got kind=%0d char=%02h code=%0d fields=%0d last=%0b",
                     res_if.kind, res_if.out_char, res_if.error_code,
                     res_if.row_fields, res_if.is_last);
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        int      base;
        result_t want;
        if (rst_n && byte_if.valid && byte_if.ready)
        begin
            base = pending_results.size();
            predict_results(byte_if.in_char, byte_if.end_of_input);
            if (stim_q[accept_idx].fixed)
            begin
                // typed-in result replaces the prediction
                while (pending_results.size() > base)
                    void'(pending_results.pop_back());
                want.kind       = stim_q[accept_idx].kind;
                want.out_char   = stim_q[accept_idx].out_char;
                want.error_code = stim_q[accept_idx].code;
                want.row_fields = 8'd0;
                want.is_last    = 1'b1;
                pending_results.push_back(want);
            end
            accept_idx++;
        end
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                want = '0;
                note_mismatch("no result pending", want);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_if.kind !== want.kind || res_if.out_char !== want.out_char ||
                    res_if.error_code !== want.error_code ||
                    res_if.row_fields !== want.row_fields || res_if.is_last !== want.is_last)
                    note_mismatch("field differs", want);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[csv_rfc4180_byte_parser] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int idx;
        int waited;
        rst_n                = 1'b0;
        byte_if.valid        = 1'b0;
        byte_if.in_char      = 8'h00;
        byte_if.end_of_input = 1'b0;
        reset_parser();
        build_stimulus();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (idx = 0; idx < stim_q.size(); idx++)
            send_item(stim_q[idx], idx);
        byte_if.valid <= 1'b0;
        calm = 1'b0;
        @(posedge clk);
        // drain outstanding results
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            mismatch_cnt += pending_results.size();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("[csv_rfc4180_byte_parser] OK");
        else
            $display("[csv_rfc4180_byte_parser] ERROR");
        $finish;
    end

endmodule
